// ===== rtl/core/strm_pkg.sv =====
// Shared types and constants for the segment tree range-max block.
// Request and response words, request codes, value limits, signed max.
// No dependencies.
package strm_pkg;

  localparam int VAL_W = 48;
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    REQ_SET = 2'd0,
    REQ_ADD = 2'd1,
    REQ_GET = 2'd2,
    REQ_MAX = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [9:0]  index;
    logic [10:0] right_end;
    val_t        value;
  } req_t;

  typedef struct packed {
    val_t result_value;
    logic status;
  } rsp_t;

  function automatic val_t smax(input val_t a, input val_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/strm_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the tree node store. No dependencies.
module strm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/segment_tree_range_max.sv =====
// Segment tree range-max engine: top level with sequencer and output register.
// Depends on strm_pkg and strm_ram.
//
//  channel | dir | handshake               | word
//  --------+-----+-------------------------+-------------------------------
//  req     | in  | req_valid / req_stall   | strm_pkg::req_t
//  rsp     | out | rsp_valid / rsp_stall   | strm_pkg::rsp_t
//  cfg     | in  | cfg_we (no wait)        | cfg_wdata = leaves_in_use
//
// One request at a time; the next one is taken once the sequencer is back in
// ST_IDLE after loading the response word. A set writes the leaf, an add reads
// it and writes the saturated sum, and both then climb the tree on the single
// node RAM port, per level reading the sibling, then writing the parent max; a
// get reads the leaf, a range max walks l and r up, errors go to ST_FINISH.
// After reset a clearing pass writes zero to all 2*SIZE nodes while req_stall
// is held; cfg writes are taken meanwhile.
// A finished word waits in the output register; a new request is taken
// while it is stalled, and that request holds in its last cycle until the
// register frees.
module segment_tree_range_max #(
  parameter int LEAVES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  strm_pkg::req_t              req_word,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output strm_pkg::rsp_t              rsp_word,
  input  logic                        cfg_we,
  input  logic [strm_pkg::CFG_W-1:0]  cfg_wdata
);

  // tree geometry: leaves sit at SIZE..2*SIZE-1, root at 1
  localparam int SIZE  = 1 << $clog2(LEAVES);
  localparam int DEPTH = 2 * SIZE;
  localparam int AW    = $clog2(DEPTH);
  // wide enough for l/r up to 2*SIZE and for the 11-bit request fields
  localparam int EW    = (AW + 1 > strm_pkg::CFG_W) ? AW + 1 : strm_pkg::CFG_W;

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_LEAF_RD   = 9'b000000100,
    ST_LEAF_DATA = 9'b000001000,
    ST_UP_RD     = 9'b000010000,
    ST_UP_WB     = 9'b000100000,
    ST_QRY_L     = 9'b001000000,
    ST_QRY_R     = 9'b010000000,
    ST_FINISH    = 9'b100000000
  } state_t;

  state_t                      state;
  logic [strm_pkg::CFG_W-1:0]  cfg_reg;
  logic [AW-1:0]               clr_cnt;
  strm_pkg::req_kind_t         kind;
  logic                        bad;
  strm_pkg::val_t              value_r;
  logic [EW-1:0]               node_a;   // leaf/current node, or query l
  logic [EW-1:0]               node_b;   // query r
  strm_pkg::val_t              cur;      // value of node_a on the way up
  strm_pkg::val_t              acc_l;
  strm_pkg::val_t              acc_r;
  logic                        pend_l;
  logic                        pend_r;
  strm_pkg::val_t              res;

  // RAM port
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  strm_pkg::val_t              ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  strm_pkg::val_t              ram_rdata;

  // request decode
  logic [EW-1:0]               n_eff;
  logic [EW-1:0]               idx_ext;
  logic [EW-1:0]               rend_ext;
  logic                        req_err;
  logic                        req_take;
  logic                        rsp_free;

  // arithmetic on the node path
  logic signed [strm_pkg::VAL_W:0] sum_wide;
  strm_pkg::val_t              sum_sat;
  strm_pkg::val_t              up_max;
  logic                        q_live;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // effective leaf count is min(register, LEAVES)
  always_comb begin
    n_eff = (EW'(cfg_reg) > EW'(LEAVES)) ? EW'(LEAVES) : EW'(cfg_reg);
  end

  assign idx_ext  = EW'(req_word.index);
  assign rend_ext = EW'(req_word.right_end);

  always_comb begin
    if (req_word.req_type == strm_pkg::REQ_MAX) begin
      req_err = !((idx_ext <= rend_ext) && (rend_ext <= n_eff));
    end else begin
      req_err = (idx_ext >= n_eff);
    end
  end

  // saturating add on the leaf: 49-bit sum, clamp on overflow
  assign sum_wide = {ram_rdata[strm_pkg::VAL_W-1], ram_rdata}
                  + {value_r[strm_pkg::VAL_W-1], value_r};
  always_comb begin
    if (sum_wide[strm_pkg::VAL_W] != sum_wide[strm_pkg::VAL_W-1]) begin
      sum_sat = sum_wide[strm_pkg::VAL_W] ? strm_pkg::VAL_MIN : strm_pkg::VAL_MAX;
    end else begin
      sum_sat = sum_wide[strm_pkg::VAL_W-1:0];
    end
  end

  assign up_max = strm_pkg::smax(cur, ram_rdata);
  assign q_live = (node_a < node_b);

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_a[AW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = node_a[AW-1:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      ST_LEAF_RD: begin
        ram_re = 1'b1;
      end
      ST_LEAF_DATA: begin
        if (kind == strm_pkg::REQ_SET) begin
          ram_we    = 1'b1;
          ram_wdata = value_r;
        end else if (kind == strm_pkg::REQ_ADD) begin
          ram_we    = 1'b1;
          ram_wdata = sum_sat;
        end
      end
      ST_UP_RD: begin
        // sibling of the current node
        ram_re    = (node_a != EW'(1));
        ram_raddr = {node_a[AW-1:1], ~node_a[0]};
      end
      ST_UP_WB: begin
        ram_we    = 1'b1;
        ram_waddr = node_a[AW:1];
        ram_wdata = up_max;
      end
      ST_QRY_L: begin
        ram_re = q_live && node_a[0];
      end
      ST_QRY_R: begin
        ram_re    = node_b[0];
        ram_raddr = node_b[AW-1:0] - AW'(1);
      end
      ST_IDLE, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  strm_ram #(
    .WIDTH (strm_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      cfg_reg   <= strm_pkg::CFG_RESET;
      pend_l    <= 1'b0;
      pend_r    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_reg <= cfg_wdata;
      end

      // query reads land in the cycle after issue
      if (pend_l) begin
        acc_l <= strm_pkg::smax(acc_l, ram_rdata);
      end
      if (pend_r) begin
        acc_r <= strm_pkg::smax(ram_rdata, acc_r);
      end
      pend_l <= (state == ST_QRY_L) && q_live && node_a[0];
      pend_r <= (state == ST_QRY_R) && node_b[0];

      // in FINISH the register is reloaded below instead
      if (rsp_valid && !rsp_stall && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_take) begin
            kind    <= req_word.req_type;
            value_r <= req_word.value;
            bad     <= req_err;
            res     <= '0;
            acc_l   <= '0;
            acc_r   <= '0;
            node_a  <= idx_ext + EW'(SIZE);
            node_b  <= rend_ext + EW'(SIZE);
            if (req_err) begin
              state <= ST_FINISH;
            end else begin
              unique case (req_word.req_type)
                strm_pkg::REQ_SET: state <= ST_LEAF_DATA;
                strm_pkg::REQ_ADD: state <= ST_LEAF_RD;
                strm_pkg::REQ_GET: state <= ST_LEAF_RD;
                strm_pkg::REQ_MAX: state <= ST_QRY_L;
                default:           state <= ST_FINISH;
              endcase
            end
          end
        end
        ST_LEAF_RD: begin
          state <= ST_LEAF_DATA;
        end
        ST_LEAF_DATA: begin
          if (kind == strm_pkg::REQ_GET) begin
            res   <= ram_rdata;
            state <= ST_FINISH;
          end else begin
            cur   <= ram_wdata;
            state <= ST_UP_RD;
          end
        end
        ST_UP_RD: begin
          state <= (node_a == EW'(1)) ? ST_FINISH : ST_UP_WB;
        end
        ST_UP_WB: begin
          cur    <= up_max;
          node_a <= node_a >> 1;
          state  <= ST_UP_RD;
        end
        ST_QRY_L: begin
          if (q_live) begin
            if (node_a[0]) begin
              node_a <= node_a + EW'(1);
            end
            state <= ST_QRY_R;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_QRY_R: begin
          // odd r: (r-1)>>1 equals r>>1
          node_a <= node_a >> 1;
          node_b <= node_b >> 1;
          state  <= ST_QRY_L;
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp_valid           <= 1'b1;
            rsp_word.status     <= bad;
            rsp_word.result_value <= (kind == strm_pkg::REQ_MAX && !bad)
                                   ? strm_pkg::smax(acc_l, acc_r) : res;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/strm_checker.sv =====
// Port-level checks for segment_tree_range_max, attached by bind.
// Depends on strm_pkg.
module strm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input strm_pkg::rsp_t              rsp_word
);

  // clearing pass holds off requests right after reset
  a_reset_stall: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request side open right after reset");

  // one request in flight: taking a word closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request taken while busy");

  // an error word never carries data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_word.status) |-> (rsp_word.result_value == '0))
    else $error("error response with nonzero value");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
    else $error("stalled response changed");

endmodule

bind segment_tree_range_max strm_checker u_strm_checker (.*);
